### sv/prcf_pkg.sv
`default_nettype none
package prcf_pkg;

  localparam int unsigned NumRules         = 8;
  localparam int unsigned RuleCountDefault = 8;
  localparam int unsigned QueueDepth       = 4;
  localparam int unsigned AddrW            = 6;
  localparam int unsigned DataW            = 64;
  localparam int unsigned UnitW            = 16;
  localparam int unsigned PosW             = 31;
  localparam int unsigned RuleW            = 2 * UnitW + UnitW + 1;

  // Packing of one pair rule register.
  typedef struct packed {
    logic             one_for_two;
    logic [UnitW-1:0] prev;
    logic [UnitW-1:0] cur;
    logic [UnitW-1:0] repl;
  } rule_t;

  // Results of one input transaction: one or two units.
  typedef struct packed {
    logic             two;
    logic [UnitW-1:0] unit0;
    logic [PosW-1:0]  off0;
    logic [UnitW-1:0] unit1;
    logic [PosW-1:0]  off1;
    logic             string_end;
  } entry_t;

endpackage
`default_nettype wire

### sv/prcf_front.sv
`default_nettype none
module prcf_front #(
  parameter int unsigned RuleCount = prcf_pkg::RuleCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  prcf_pkg::rule_t              rules_i [prcf_pkg::NumRules],
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [prcf_pkg::UnitW-1:0]   code_unit_i,
  input  logic                         first_unit_i,
  input  logic                         last_unit_i,
  input  logic [prcf_pkg::PosW-1:0]    start_position_i,
  output logic                         push_o,
  output prcf_pkg::entry_t             entry_o,
  input  logic                         push_ready_i
);
  import prcf_pkg::*;

  logic [UnitW-1:0] held_unit_q, held_unit_d;
  logic             held_valid_q, held_valid_d;
  logic [PosW-1:0]  held_pos_q, held_pos_d;

  logic             accept;
  logic             have;
  logic [PosW-1:0]  pos;
  logic [PosW-1:0]  pos_next;
  logic             hit;
  logic             done;
  rule_t            hit_rule;
  logic             has_result;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign have       = ~first_unit_i & held_valid_q;
  assign pos        = first_unit_i ? start_position_i :
                      (held_valid_q ? held_pos_q + 1'b1 : held_pos_q);
  assign pos_next   = pos + 1'b1;

  // First matching rule wins; a zero replacement closes the list.
  always_comb begin
    hit      = 1'b0;
    done     = 1'b0;
    hit_rule = '0;
    for (int i = 0; i < RuleCount; i++) begin
      if (!done) begin
        if (rules_i[i].repl == '0) begin
          done = 1'b1;
        end else if (rules_i[i].prev == held_unit_q && rules_i[i].cur == code_unit_i) begin
          hit      = 1'b1;
          done     = 1'b1;
          hit_rule = rules_i[i];
        end
      end
    end
  end

  always_comb begin
    entry_o            = '0;
    entry_o.string_end = last_unit_i;
    has_result         = 1'b1;
    held_unit_d        = held_unit_q;
    held_valid_d       = 1'b0;
    held_pos_d         = pos_next;
    if (!have) begin
      entry_o.unit0 = code_unit_i;
      entry_o.off0  = pos;
      if (!last_unit_i) begin
        has_result   = 1'b0;
        held_unit_d  = code_unit_i;
        held_valid_d = 1'b1;
        held_pos_d   = pos;
      end
    end else if (hit) begin
      entry_o.unit0 = hit_rule.repl;
      if (hit_rule.one_for_two) begin
        entry_o.off0 = pos;
      end else begin
        entry_o.two   = 1'b1;
        entry_o.off0  = held_pos_q;
        entry_o.unit1 = code_unit_i;
        entry_o.off1  = pos;
      end
    end else begin
      entry_o.unit0 = held_unit_q;
      entry_o.off0  = held_pos_q;
      if (last_unit_i) begin
        entry_o.two   = 1'b1;
        entry_o.unit1 = code_unit_i;
        entry_o.off1  = pos;
      end else begin
        held_unit_d  = code_unit_i;
        held_valid_d = 1'b1;
        held_pos_d   = pos;
      end
    end
  end

  assign push_o = accept & has_result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_unit_q  <= '0;
      held_valid_q <= 1'b0;
      held_pos_q   <= '0;
    end else if (accept) begin
      held_unit_q  <= held_unit_d;
      held_valid_q <= held_valid_d;
      held_pos_q   <= held_pos_d;
    end
  end

endmodule
`default_nettype wire

### sv/prcf_queue.sv
`default_nettype none
module prcf_queue #(
  parameter int unsigned Depth = prcf_pkg::QueueDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  prcf_pkg::entry_t             entry_i,
  output logic                         push_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [prcf_pkg::UnitW-1:0]   out_unit_o,
  output logic [prcf_pkg::PosW-1:0]    source_offset_o,
  output logic                         run_last_o,
  output logic                         string_end_o
);
  import prcf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              sel_q, sel_d;
  entry_t            head;
  logic              do_push;
  logic              do_pop;
  logic              out_take;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign do_push      = push_i & push_ready_o;
  assign head         = mem_q[rd_ptr_q];

  assign out_valid_o     = (cnt_q != '0);
  assign out_unit_o      = sel_q ? head.unit1 : head.unit0;
  assign source_offset_o = sel_q ? head.off1 : head.off0;
  assign run_last_o      = ~head.two | sel_q;
  assign string_end_o    = head.string_end & run_last_o;

  assign out_take = out_valid_o & out_ready_i;
  // An entry of two units leaves the queue only after its second transaction.
  assign do_pop   = out_take & run_last_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    sel_d    = sel_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (out_take) begin
      sel_d = ~run_last_o;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      sel_q    <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
      sel_q    <= sel_d;
    end
  end

endmodule
`default_nettype wire

### sv/pair_rule_char_folder.sv
// Results of an accepted input transaction are registered in the result queue, then offered.
// Throughput: one input transaction per cycle while the four-entry result queue has room;
// output moves one unit per cycle while out_ready_i is high; two results leave one at a time.
// Rule matching compares the first RULE_COUNT rules combinationally with held and new units.
// Reset: all rules read zero, nothing is held, positions start at zero and the queue is empty.
`default_nettype none
module pair_rule_char_folder #(
  parameter int unsigned RULE_COUNT = prcf_pkg::RuleCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [prcf_pkg::AddrW-1:0]   paddr,
  input  logic [prcf_pkg::DataW-1:0]   pwdata,
  output logic [prcf_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [prcf_pkg::UnitW-1:0]   code_unit_i,
  input  logic                         first_unit_i,
  input  logic                         last_unit_i,
  input  logic [prcf_pkg::PosW-1:0]    start_position_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [prcf_pkg::UnitW-1:0]   out_unit_o,
  output logic [prcf_pkg::PosW-1:0]    source_offset_o,
  output logic                         run_last_o,
  output logic                         string_end_o
);
  import prcf_pkg::*;

  localparam int unsigned IdxW = $clog2(NumRules);

  rule_t           rule_q [NumRules];
  logic [IdxW-1:0] reg_idx;
  logic            cfg_write;
  logic            push;
  logic            push_ready;
  entry_t          entry;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[IdxW+2:3];
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = {{(DataW - RuleW){1'b0}}, rule_q[reg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRules; i++) begin
        rule_q[i] <= '0;
      end
    end else if (cfg_write) begin
      rule_q[reg_idx] <= pwdata[RuleW-1:0];
    end
  end

  prcf_front #(
    .RuleCount (RULE_COUNT)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rules_i          (rule_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .code_unit_i      (code_unit_i),
    .first_unit_i     (first_unit_i),
    .last_unit_i      (last_unit_i),
    .start_position_i (start_position_i),
    .push_o           (push),
    .entry_o          (entry),
    .push_ready_i     (push_ready)
  );

  prcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .entry_i         (entry),
    .push_ready_o    (push_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_unit_o      (out_unit_o),
    .source_offset_o (source_offset_o),
    .run_last_o      (run_last_o),
    .string_end_o    (string_end_o)
  );

endmodule
`default_nettype wire

### sv/prcf_checker.sv
`default_nettype none
module prcf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         pready,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [prcf_pkg::UnitW-1:0]   out_unit_o,
  input logic [prcf_pkg::PosW-1:0]    source_offset_o,
  input logic                         run_last_o,
  input logic                         string_end_o
);

  // The end of a string always closes the results of its transaction.
  a_end_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string_end without run_last");

  // The configuration port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid dropped while stalled");

  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_unit_o) && $stable(source_offset_o)
      && $stable(run_last_o) && $stable(string_end_o))
    else $error("output payload changed while stalled");

endmodule

bind pair_rule_char_folder prcf_checker u_prcf_checker (.*);
`default_nettype wire

### test/pair_rule_char_folder_test.sv
module pair_rule_char_folder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import prcf_pkg::*;

  localparam int unsigned RuleCount  = RuleCountDefault;
  localparam int          CycleLimit = 400000;
  localparam int          PhaseUnits = 225;

  typedef struct {
    logic [UnitW-1:0] unit;
    logic             first;
    logic             last;
    logic [PosW-1:0]  start;
  } text_unit_t;

  typedef struct {
    logic [UnitW-1:0] unit;
    logic [PosW-1:0]  offset;
    logic             run_last;
    logic             string_end;
  } folded_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [UnitW-1:0]  code_unit_i = '0;
  logic              first_unit_i = 1'b0;
  logic              last_unit_i = 1'b0;
  logic [PosW-1:0]   start_position_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [UnitW-1:0]  out_unit_o;
  logic [PosW-1:0]   source_offset_o;
  logic              run_last_o;
  logic              string_end_o;

  // Predictor state: the rule set as last written and the pending unit.
  rule_t             rule_set[NumRules];
  logic [UnitW-1:0]  pend_unit = '0;
  logic              pend_live = 1'b0;
  logic [PosW-1:0]   pend_pos = '0;

  text_unit_t        unit_q[$];
  folded_t           folded_q[$];
  folded_t           head;
  text_unit_t        next_unit;
  logic              in_taken = 1'b0;
  logic              out_taken = 1'b0;
  int                in_wait = 0;
  int                out_wait = 0;
  int                in_calm = 0;
  int                out_calm = 0;
  int                fail_count = 0;
  int                cycle_count = 0;

  pair_rule_char_folder #(
    .RULE_COUNT(RuleCount)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .code_unit_i     (code_unit_i),
    .first_unit_i    (first_unit_i),
    .last_unit_i     (last_unit_i),
    .start_position_i(start_position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_unit_o      (out_unit_o),
    .source_offset_o (source_offset_o),
    .run_last_o      (run_last_o),
    .string_end_o    (string_end_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Works out the units that one accepted code unit folds into and queues them.
  function automatic void fold_pair(input text_unit_t u);
    folded_t          res[2];
    int               n;
    int               i;
    logic [PosW-1:0]  pos;
    logic             have;
    logic             hit;
    logic             stop;
    n = 0;
    hit = 1'b0;
    stop = 1'b0;
    if (u.first) begin
      pos = u.start;
      have = 1'b0;
    end else begin
      have = pend_live;
      pos = have ? pend_pos + 1'b1 : pend_pos;
    end
    if (!have) begin
      if (u.last) begin
        res[0] = '{unit: u.unit, offset: pos, run_last: 1'b0, string_end: 1'b0};
        n = 1;
        pend_live = 1'b0;
        pend_pos = pos + 1'b1;
      end else begin
        pend_unit = u.unit;
        pend_live = 1'b1;
        pend_pos = pos;
      end
    end else begin
      for (i = 0; i < RuleCount && !stop; i++) begin
        if (rule_set[i].repl == '0) begin
          stop = 1'b1;
        end else if (rule_set[i].prev == pend_unit && rule_set[i].cur == u.unit) begin
          if (rule_set[i].one_for_two) begin
            res[0] = '{unit: rule_set[i].repl, offset: pos, run_last: 1'b0, string_end: 1'b0};
            n = 1;
          end else begin
            res[0] = '{unit: rule_set[i].repl, offset: pend_pos, run_last: 1'b0,
                       string_end: 1'b0};
            res[1] = '{unit: u.unit, offset: pos, run_last: 1'b0, string_end: 1'b0};
            n = 2;
          end
          hit = 1'b1;
          stop = 1'b1;
        end
      end
      if (hit) begin
        pend_live = 1'b0;
        pend_pos = pos + 1'b1;
      end else begin
        res[0] = '{unit: pend_unit, offset: pend_pos, run_last: 1'b0, string_end: 1'b0};
        n = 1;
        if (u.last) begin
          res[1] = '{unit: u.unit, offset: pos, run_last: 1'b0, string_end: 1'b0};
          n = 2;
          pend_live = 1'b0;
          pend_pos = pos + 1'b1;
        end else begin
          pend_unit = u.unit;
          pend_live = 1'b1;
          pend_pos = pos;
        end
      end
    end
    if (n > 0) begin
      res[n-1].run_last = 1'b1;
      res[n-1].string_end = u.last;
    end
    for (i = 0; i < n; i++) folded_q.push_back(res[i]);
  endfunction

  // Idle cycles before the next transaction, with the odd stretch of none at all.
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 8);
  endfunction

  function automatic rule_t make_rule(input logic one, input logic [UnitW-1:0] prev,
                                      input logic [UnitW-1:0] cur,
                                      input logic [UnitW-1:0] repl);
    rule_t r;
    r.one_for_two = one;
    r.prev = prev;
    r.cur = cur;
    r.repl = repl;
    return r;
  endfunction

  task automatic write_rule(input int idx, input rule_t r);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(8 * idx);
    pwdata <= DataW'(r);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rule_set[idx] = r;
  endtask

  task automatic push_unit(input logic [UnitW-1:0] u, input logic f, input logic l,
                           input logic [PosW-1:0] s);
    unit_q.push_back('{unit: u, first: f, last: l, start: s});
  endtask

  // Returns once every queued unit has gone in and every folded unit has come out.
  task automatic wait_idle();
    while (unit_q.size() != 0 || in_valid_i || folded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Input driver.
  always @(negedge clk_i) begin
    if (!(in_valid_i && !in_taken)) begin
      if (in_wait > 0) begin
        in_valid_i <= 1'b0;
        in_wait <= in_wait - 1;
      end else if (unit_q.size() > 0) begin
        next_unit = unit_q.pop_front();
        in_valid_i <= 1'b1;
        code_unit_i <= next_unit.unit;
        first_unit_i <= next_unit.first;
        last_unit_i <= next_unit.last;
        start_position_i <= next_unit.start;
        in_wait <= draw_wait(in_calm);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk_i) begin
    if (!(out_ready_i && !out_taken)) begin
      if (out_wait > 0) begin
        out_ready_i <= 1'b0;
        out_wait <= out_wait - 1;
      end else begin
        out_ready_i <= 1'b1;
        out_wait <= draw_wait(out_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    out_taken <= rst_ni && out_valid_o && out_ready_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      fold_pair('{unit: code_unit_i, first: first_unit_i, last: last_unit_i,
                  start: start_position_i});
    end
  end

  // Each output transaction is checked against the oldest folded unit still owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (folded_q.size() == 0) begin
        $error("unexpected output unit %h at offset %h", out_unit_o, source_offset_o);
        fail_count++;
      end else begin
        head = folded_q.pop_front();
        if (out_unit_o !== head.unit) begin
          $error("out_unit: expected %h, got %h", head.unit, out_unit_o);
          fail_count++;
        end
        if (source_offset_o !== head.offset) begin
          $error("source_offset: expected %h, got %h", head.offset, source_offset_o);
          fail_count++;
        end
        if (run_last_o !== head.run_last) begin
          $error("run_last: expected %b, got %b", head.run_last, run_last_o);
          fail_count++;
        end
        if (string_end_o !== head.string_end) begin
          $error("string_end: expected %b, got %b", head.string_end, string_end_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("pair_rule_char_folder_test: done, errors");
      $finish;
    end
  end

  initial begin
    int               p;
    int               i;
    int               k;
    int               len;
    int               brk;
    int               count;
    rule_t            r;
    logic [UnitW-1:0] alpha[4];
    logic [UnitW-1:0] u;
    logic [PosW-1:0]  base;
    logic             f;
    logic             l;

    for (i = 0; i < NumRules; i++) rule_set[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The third rule repeats the first pair and must never win; the sixth ends the list,
    // so the rules behind it are dead even where their pair matches.
    write_rule(0, make_rule(1'b0, 16'h0041, 16'h0042, 16'h0058));
    write_rule(1, make_rule(1'b1, 16'h0043, 16'h0044, 16'h0059));
    write_rule(2, make_rule(1'b0, 16'h0041, 16'h0042, 16'h0057));
    write_rule(3, make_rule(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    write_rule(4, make_rule(1'b0, 16'h0000, 16'h0000, 16'h0001));
    write_rule(5, make_rule(1'b0, 16'h0045, 16'h0046, 16'h0000));
    write_rule(6, make_rule(1'b0, 16'h0045, 16'h0046, 16'h005A));
    write_rule(7, make_rule(1'b1, 16'h0047, 16'h0048, 16'h0051));

    push_unit(16'h0041, 1'b1, 1'b1, 31'h0);
    // Offsets wrap through the top of the range across a two-unit replacement.
    push_unit(16'h0041, 1'b1, 1'b0, 31'h7FFFFFFE);
    push_unit(16'h0042, 1'b0, 1'b0, 31'h7FFFFFFF);
    push_unit(16'h0043, 1'b0, 1'b0, 31'h12345678);
    push_unit(16'h0044, 1'b0, 1'b1, 31'h0);
    push_unit(16'hFFFF, 1'b1, 1'b0, 31'h7FFFFFFF);
    push_unit(16'hFFFF, 1'b0, 1'b0, 31'h0);
    push_unit(16'h0000, 1'b0, 1'b0, 31'h7FFFFFFF);
    push_unit(16'h0000, 1'b0, 1'b1, 31'h0);
    push_unit(16'h0045, 1'b1, 1'b0, 31'd5);
    push_unit(16'h0046, 1'b0, 1'b0, 31'h0);
    push_unit(16'h0047, 1'b0, 1'b0, 31'h0);
    push_unit(16'h0048, 1'b0, 1'b0, 31'h0);
    push_unit(16'h005A, 1'b0, 1'b1, 31'h0);
    // A new string while a unit is held drops that unit.
    push_unit(16'h0041, 1'b1, 1'b0, 31'd100);
    push_unit(16'h0042, 1'b1, 1'b0, 31'd200);
    push_unit(16'h0058, 1'b0, 1'b1, 31'h0);
    // Carrying on without a first mark counts on from the previous string.
    push_unit(16'h0041, 1'b0, 1'b0, 31'h0);
    push_unit(16'h0042, 1'b0, 1'b1, 31'h0);
    push_unit(16'h0051, 1'b1, 1'b0, 31'h0);
    push_unit(16'h0052, 1'b0, 1'b1, 31'h0);
    push_unit(16'h5555, 1'b1, 1'b0, 31'h2AAAAAAA);
    push_unit(16'hAAAA, 1'b0, 1'b1, 31'h55555555);
    wait_idle();

    for (p = 0; p < 7; p++) begin
      for (i = 0; i < 4; i++) begin
        case ($urandom_range(0, 5))
          0: alpha[i] = 16'h0000;
          1: alpha[i] = 16'hFFFF;
          default: alpha[i] = 16'($urandom());
        endcase
      end
      if (p == 1) alpha[0] = 16'hFFFF;
      for (i = 0; i < NumRules; i++) begin
        if (p == 0) begin
          r = '0;
        end else if (p == 1) begin
          r = '1;
        end else begin
          r.one_for_two = 1'($urandom_range(0, 1));
          r.prev = alpha[$urandom_range(0, 3)];
          r.cur = alpha[$urandom_range(0, 3)];
          r.repl = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom_range(1, 65535));
        end
        write_rule(i, r);
      end

      count = 0;
      while (count < PhaseUnits) begin
        len = $urandom_range(1, 10);
        brk = $urandom_range(0, 9);
        base = ($urandom_range(0, 3) == 0) ? 31'h7FFFFFFF - 31'($urandom_range(0, 12))
                                           : 31'($urandom());
        for (k = 0; k < len; k++) begin
          u = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : alpha[$urandom_range(0, 3)];
          // Mostly whole strings; now and then one with no first mark, a restart in
          // the middle, or no last mark so that it runs into the next.
          f = (k == 0 && brk != 0) || (brk == 1 && k == len / 2);
          l = (k == len - 1) && brk != 2;
          push_unit(u, f, l, f ? base : 31'($urandom()));
          count++;
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("pair_rule_char_folder_test: done, clean");
    end else begin
      $display("pair_rule_char_folder_test: done, errors");
    end
    $finish;
  end

endmodule
